### hdl/bully_pkg.sv
package bully_pkg;

  // Node phases as reported on the result channel.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ELECTING = 2'd1,
    PH_AWAIT    = 2'd2,
    PH_LEADER   = 2'd3
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OK,
    ST_VOTE,
    ST_LEAD
  } ctrl_state_t;

  // Input commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MSG   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Message kinds, received and sent.
  localparam logic [1:0] KIND_VOTE   = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_LEADER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_ID    = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  // Largest group the node serves; ranks are 4 bits wide.
  localparam int NODES = 16;
  localparam logic [4:0] GROUP_CAP = (NODES > 16) ? 5'd16 : 5'(NODES);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;  // take the input request and update the node state
    logic       emit;    // load the output register with one message
    logic [1:0] kind;    // kind of the emitted message
    logic       last;    // emitted message closes the run
    logic       step;    // advance the destination index
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_ok;       // the request is a vote and gets an ok reply
    logic starts_vote;  // the request starts an election
    logic starts_lead;  // the request makes this node leader
    logic vote_empty;   // no higher rank in the group
    logic lead_empty;   // no other rank in the group
    logic vote_last;    // current vote destination is the last one
    logic lead_last;    // current leader destination is the last one
  } dp_stat_t;

endpackage

### hdl/bully_election_node.sv
// Channel  Handshake             Payload
// in_      in_valid / in_ready   command, msg_kind, msg_source, msg_value
// out_     out_valid / out_ready send_kind, send_dest, send_value, last_of_run,
//                                leader_id, phase_now
// cfg_     cfg_we                cfg_index, cfg_wdata
//
// A request is taken in the idle state; the messages it causes are then loaded
// into the output register one by one, and no new request is taken until the
// last of them is loaded (up to sixteen: an ok and fifteen votes). The sweep
// counter over the group ranks steps the destinations. Reset is synchronous and
// active low; it clears the phase, countdown, leader and payload and restores
// the configuration defaults. A stalled output holds the sweep in place; the next
// request is taken while the last message of a run still waits in the output.
module bully_election_node
  import bully_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_msg_kind,
  input  logic [3:0]  in_msg_source,
  input  logic [31:0] in_msg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_send_kind,
  output logic [3:0]  out_send_dest,
  output logic [31:0] out_send_value,
  output logic        out_last_of_run,
  output logic [3:0]  out_leader_id,
  output logic [1:0]  out_phase_now
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for requests and outgoing messages.
  bully_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Node state, configuration and output register.
  bully_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_msg_kind     (in_msg_kind),
    .in_msg_source   (in_msg_source),
    .in_msg_value    (in_msg_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_send_kind   (out_send_kind),
    .out_send_dest   (out_send_dest),
    .out_send_value  (out_send_value),
    .out_last_of_run (out_last_of_run),
    .out_leader_id   (out_leader_id),
    .out_phase_now   (out_phase_now)
  );

endmodule

### hdl/bully_dp.sv
module bully_dp
  import bully_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_msg_kind,
  input  logic [3:0]  in_msg_source,
  input  logic [31:0] in_msg_value,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [1:0]  out_send_kind,
  output logic [3:0]  out_send_dest,
  output logic [31:0] out_send_value,
  output logic        out_last_of_run,
  output logic [3:0]  out_leader_id,
  output logic [1:0]  out_phase_now
);

  logic [3:0]  node_id_r;
  logic [4:0]  node_count_r;
  logic [15:0] timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [3:0]  leader_r, leader_nxt;
  logic [31:0] payload_r, payload_nxt;
  logic [3:0]  src_r;
  logic [4:0]  idx_r, idx_nxt;

  logic [1:0]  kind_r;
  logic [3:0]  dest_r;
  logic [31:0] value_r;
  logic        last_r;
  logic [3:0]  lid_r;
  phase_t      ph_r;

  logic [4:0]  group_n;
  logic [4:0]  vote_start;
  logic [4:0]  lead_start;
  logic [4:0]  lead_next;
  logic [4:0]  vote_next;
  logic [15:0] timeout_eff;

  // Group size and sweep bounds.
  assign group_n     = (node_count_r > GROUP_CAP) ? GROUP_CAP : node_count_r;
  assign vote_start  = {1'b0, node_id_r} + 5'd1;
  assign lead_start  = (node_id_r == 4'd0) ? 5'd1 : 5'd0;
  assign vote_next   = idx_r + 5'd1;
  assign lead_next   = (vote_next == {1'b0, node_id_r}) ? idx_r + 5'd2 : vote_next;
  assign timeout_eff = (timeout_r == 16'd0) ? 16'd1 : timeout_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= 4'd0;
      node_count_r <= 5'd16;
      timeout_r    <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ID:    node_id_r    <= cfg_wdata[3:0];
        REG_NODE_COUNT: node_count_r <= cfg_wdata[4:0];
        REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode the request against the current phase and work out the new state.
  always_comb begin
    phase_nxt        = phase_r;
    countdown_nxt    = countdown_r;
    leader_nxt       = leader_r;
    payload_nxt      = payload_r;
    stat.has_ok      = 1'b0;
    stat.starts_vote = 1'b0;
    stat.starts_lead = 1'b0;
    stat.vote_empty  = (vote_start >= group_n);
    stat.lead_empty  = (lead_start >= group_n);
    stat.vote_last   = (vote_next >= group_n);
    stat.lead_last   = (lead_next >= group_n);
    unique case (in_command)
      CMD_TICK: begin
        if (phase_r == PH_ELECTING) begin
          if (countdown_r <= 16'd1) begin
            countdown_nxt    = 16'd0;
            phase_nxt        = PH_LEADER;
            leader_nxt       = node_id_r;
            stat.starts_lead = 1'b1;
          end else begin
            countdown_nxt = countdown_r - 16'd1;
          end
        end
      end
      CMD_MSG: begin
        unique case (in_msg_kind)
          KIND_VOTE: begin
            payload_nxt = in_msg_value;
            stat.has_ok = 1'b1;
            if (phase_r != PH_ELECTING) begin
              phase_nxt        = PH_ELECTING;
              countdown_nxt    = timeout_eff;
              stat.starts_vote = 1'b1;
            end
          end
          KIND_OK: begin
            if (phase_r == PH_ELECTING) begin
              payload_nxt   = in_msg_value;
              countdown_nxt = 16'd0;
              phase_nxt     = PH_AWAIT;
            end
          end
          KIND_LEADER: begin
            if (phase_r != PH_ELECTING) begin
              payload_nxt = in_msg_value;
              leader_nxt  = in_msg_source;
              phase_nxt   = PH_LEADER;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        if (phase_r != PH_ELECTING) begin
          phase_nxt        = PH_ELECTING;
          countdown_nxt    = timeout_eff;
          stat.starts_vote = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Node state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      countdown_r <= 16'd0;
      leader_r    <= 4'd0;
      payload_r   <= 32'd0;
    end else if (cmd.accept) begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      leader_r    <= leader_nxt;
      payload_r   <= payload_nxt;
    end
  end

  // Destination index: loaded with the first rank of the sweep, then stepped.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = stat.starts_lead ? lead_start : vote_start;
    end else if (cmd.step) begin
      idx_nxt = (cmd.kind == KIND_LEADER) ? lead_next : vote_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      src_r <= in_msg_source;
    end
  end

  // Output register: one message with the node state it reports.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r  <= cmd.kind;
      dest_r  <= (cmd.kind == KIND_OK) ? src_r : idx_r[3:0];
      value_r <= payload_r;
      last_r  <= cmd.last;
      lid_r   <= leader_r;
      ph_r    <= phase_r;
    end
  end

  assign out_send_kind   = kind_r;
  assign out_send_dest   = dest_r;
  assign out_send_value  = value_r;
  assign out_last_of_run = last_r;
  assign out_leader_id   = lid_r;
  assign out_phase_now   = ph_r;

endmodule

### hdl/bully_ctrl.sv
module bully_ctrl
  import bully_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        elect_r, elect_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // The output register can take a message when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    elect_nxt = elect_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          elect_nxt  = stat.starts_vote;
          if (stat.has_ok) begin
            state_nxt = ST_OK;
          end else if (stat.starts_vote && !stat.vote_empty) begin
            state_nxt = ST_VOTE;
          end else if (stat.starts_lead && !stat.lead_empty) begin
            state_nxt = ST_LEAD;
          end
        end
      end
      ST_OK: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_OK;
          cmd.last  = !(elect_r && !stat.vote_empty);
          state_nxt = cmd.last ? ST_IDLE : ST_VOTE;
        end
      end
      ST_VOTE: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_VOTE;
          cmd.last  = stat.vote_last;
          cmd.step  = 1'b1;
          state_nxt = stat.vote_last ? ST_IDLE : ST_VOTE;
        end
      end
      ST_LEAD: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_LEADER;
          cmd.last  = stat.lead_last;
          cmd.step  = 1'b1;
          state_nxt = stat.lead_last ? ST_IDLE : ST_LEAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid flag follows loads and drains of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elect_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elect_r     <= elect_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### dv/bully_election_node_test.sv
`timescale 1ns / 1ps

module bully_election_node_test;
  import bully_pkg::*;

  // Codes outside the defined sets; the node must ignore them.
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One outgoing message as seen on the result channel.
  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  dest;
    logic [31:0] value;
    logic        last;
    logic [3:0]  leader;
    phase_t      phase;
  } message_t;

  // Mirror of one election node: tracks its state and owes the messages it sends.
  class election_mirror;
    logic [3:0]  rank;
    logic [4:0]  group_total;
    logic [15:0] tmo_ticks;
    phase_t      phase;
    logic [15:0] countdown;
    logic [3:0]  leader;
    logic [31:0] payload;
    logic [1:0]  run_kinds[$];
    logic [3:0]  run_dests[$];
    message_t    owed_msgs[$];
    int          mismatch_count;

    function new();
      rank = 4'd0;
      group_total = 5'd16;
      tmo_ticks = 16'd5;
      phase = PH_IDLE;
      countdown = 16'd0;
      leader = 4'd0;
      payload = 32'd0;
      mismatch_count = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_NODE_ID: rank = data[3:0];
        REG_NODE_COUNT: group_total = data[4:0];
        REG_TIMEOUT: tmo_ticks = data;
        default: ;
      endcase
    endfunction

    // Ranks in use: the configured count, capped by the node's capacity.
    function int group_span();
      int n;
      n = group_total;
      if (n > NODES) n = NODES;
      if (n > 16) n = 16;
      return n;
    endfunction

    // Enter the electing phase and send a vote to every higher rank.
    function void open_election();
      phase = PH_ELECTING;
      countdown = (tmo_ticks == 16'd0) ? 16'd1 : tmo_ticks;
      for (int i = int'(rank) + 1; i < group_span(); i++) begin
        run_kinds.push_back(KIND_VOTE);
        run_dests.push_back(4'(i));
      end
    endfunction

    // Update the node state for an accepted request and queue its messages.
    function void note_request(logic [1:0] cmd, logic [1:0] kind, logic [3:0] src,
                               logic [31:0] value);
      message_t m;
      run_kinds.delete();
      run_dests.delete();
      case (cmd)
        CMD_TICK: begin
          if (phase == PH_ELECTING) begin
            if (countdown <= 16'd1) begin
              countdown = 16'd0;
              phase = PH_LEADER;
              leader = rank;
              for (int i = 0; i < group_span(); i++) begin
                if (i != int'(rank)) begin
                  run_kinds.push_back(KIND_LEADER);
                  run_dests.push_back(4'(i));
                end
              end
            end else begin
              countdown = countdown - 16'd1;
            end
          end
        end
        CMD_MSG: begin
          case (kind)
            KIND_VOTE: begin
              payload = value;
              run_kinds.push_back(KIND_OK);
              run_dests.push_back(src);
              if (phase != PH_ELECTING) open_election();
            end
            KIND_OK: begin
              if (phase == PH_ELECTING) begin
                payload = value;
                countdown = 16'd0;
                phase = PH_AWAIT;
              end
            end
            KIND_LEADER: begin
              if (phase != PH_ELECTING) begin
                payload = value;
                leader = src;
                phase = PH_LEADER;
              end
            end
            default: ;
          endcase
        end
        CMD_START: begin
          if (phase != PH_ELECTING) open_election();
        end
        default: ;
      endcase
      // Every message of the run carries the state reached after the request.
      foreach (run_kinds[j]) begin
        m.kind = run_kinds[j];
        m.dest = run_dests[j];
        m.value = payload;
        m.last = (j == run_kinds.size() - 1);
        m.leader = leader;
        m.phase = phase;
        owed_msgs.push_back(m);
      end
    endfunction

    // Compare a delivered message with the oldest one owed.
    function void check_message(message_t got);
      message_t want;
      if (owed_msgs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected message: kind %0d dest %0d value %h", got.kind, got.dest,
                   got.value);
        return;
      end
      want = owed_msgs.pop_front();
      if (want.kind !== got.kind || want.dest !== got.dest || want.value !== got.value ||
          want.last !== got.last || want.leader !== got.leader || want.phase !== got.phase)
      begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"message mismatch (expected/actual): kind %0d/%0d dest %0d/%0d ",
                    "value %h/%h last %0d/%0d leader %0d/%0d phase %0d/%0d"},
                   want.kind, got.kind, want.dest, got.dest, want.value, got.value,
                   want.last, got.last, want.leader, got.leader, want.phase, got.phase);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = 2'd0;
  logic [1:0]  in_msg_kind = 2'd0;
  logic [3:0]  in_msg_source = 4'd0;
  logic [31:0] in_msg_value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_send_kind;
  logic [3:0]  out_send_dest;
  logic [31:0] out_send_value;
  logic        out_last_of_run;
  logic [3:0]  out_leader_id;
  logic [1:0]  out_phase_now;

  election_mirror mirror;
  logic calm = 1'b0;

  bully_election_node DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_msg_kind(in_msg_kind),
    .in_msg_source(in_msg_source),
    .in_msg_value(in_msg_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_send_kind(out_send_kind),
    .out_send_dest(out_send_dest),
    .out_send_value(out_send_value),
    .out_last_of_run(out_last_of_run),
    .out_leader_id(out_leader_id),
    .out_phase_now(out_phase_now)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls now and then, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Watch both channels; a message is checked before a new request is noted.
  always @(posedge clk) begin
    message_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.kind = out_send_kind;
        seen.dest = out_send_dest;
        seen.value = out_send_value;
        seen.last = out_last_of_run;
        seen.leader = out_leader_id;
        seen.phase = phase_t'(out_phase_now);
        mirror.check_message(seen);
      end
      if (in_valid && in_ready)
        mirror.note_request(in_command, in_msg_kind, in_msg_source, in_msg_value);
    end
  end

  // Offer one request and hold it until the node takes it.
  task automatic send_request(input logic [1:0] cmd, input logic [1:0] kind,
                              input logic [3:0] src, input logic [31:0] value);
    if (!calm) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_msg_kind <= kind;
    in_msg_source <= src;
    in_msg_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    mirror.write_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and let every owed message drain, then let the node go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.owed_msgs.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  cmd;
    logic [1:0]  kind;
    logic [3:0]  node_rank;
    logic [4:0]  node_total;
    logic [15:0] tmo;
    int          sel;

    mirror = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the phases with the reset configuration.
    send_request(CMD_TICK, KIND_LEADER, 4'hF, 32'hFFFF_FFFF);
    send_request(CMD_MSG, KIND_OK, 4'h0, 32'hFFFF_FFFF);
    send_request(CMD_MSG, KIND_LEADER, 4'hF, 32'h8000_0001);
    send_request(CMD_START, KIND_VOTE, 4'h0, 32'h0);
    send_request(CMD_START, KIND_OK, 4'h5, 32'h1);
    send_request(CMD_MSG, KIND_LEADER, 4'h9, 32'h1234_5678);
    send_request(CMD_MSG, KIND_VOTE, 4'hF, 32'hA5A5_A5A5);
    send_request(CMD_MSG, KIND_OK, 4'h3, 32'h0);
    send_request(CMD_TICK, KIND_VOTE, 4'h0, 32'h0);
    send_request(CMD_MSG, KIND_VOTE, 4'h2, 32'h5A5A_5A5A);
    repeat (5) send_request(CMD_TICK, KIND_VOTE, 4'h6, 32'h0);
    send_request(CMD_UNUSED, KIND_VOTE, 4'h7, 32'hFFFF_FFFF);
    send_request(CMD_MSG, KIND_UNUSED, 4'h7, 32'hFFFF_FFFF);

    // Highest rank with a zero timeout: no votes, then leadership on one tick.
    settle();
    write_reg(REG_NODE_ID, 16'd15);
    write_reg(REG_TIMEOUT, 16'd0);
    send_request(CMD_START, KIND_VOTE, 4'h0, 32'h0);
    send_request(CMD_TICK, KIND_VOTE, 4'h0, 32'h0);

    // An empty group sends nothing but the ok reply.
    settle();
    write_reg(REG_NODE_COUNT, 16'd0);
    send_request(CMD_MSG, KIND_VOTE, 4'h4, 32'h0F0F_0F0F);
    send_request(CMD_TICK, KIND_VOTE, 4'h0, 32'h0);

    // Random traffic under several configurations.
    for (int p = 0; p < 6; p++) begin
      settle();
      node_rank = 4'($urandom_range(0, 15));
      case (p)
        0: begin node_rank = 4'd0; node_total = 5'd16; tmo = 16'd1; end
        1: begin node_rank = 4'd15; node_total = 5'd16; tmo = 16'd2; end
        2: begin node_rank = 4'd12; node_total = 5'd5; tmo = 16'd3; end
        3: begin node_total = 5'd31; tmo = 16'hFFFF; end
        4: begin
          node_total = 5'($urandom_range(2, 16));
          tmo = 16'($urandom_range(1, 4));
        end
        default: begin node_total = 5'd1; tmo = 16'd2; end
      endcase
      write_reg(REG_NODE_ID, {12'd0, node_rank});
      write_reg(REG_NODE_COUNT, {11'd0, node_total});
      write_reg(REG_TIMEOUT, tmo);
      calm = (p == 4);
      repeat (40) begin
        sel = $urandom_range(0, 99);
        cmd = CMD_MSG;
        kind = 2'($urandom_range(0, 3));
        if (sel < 32) cmd = CMD_TICK;
        else if (sel < 54) kind = KIND_VOTE;
        else if (sel < 66) kind = KIND_OK;
        else if (sel < 76) kind = KIND_LEADER;
        else if (sel < 92) cmd = CMD_START;
        else if ($urandom_range(0, 1) == 0) cmd = CMD_UNUSED;
        else kind = KIND_UNUSED;
        send_request(cmd, kind, 4'($urandom_range(0, 15)), $urandom);
      end
    end
    calm = 1'b0;

    settle();
    if (mirror.mismatch_count == 0 && mirror.owed_msgs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the node hangs.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hdl/bully_pkg.sv
hdl/bully_dp.sv
hdl/bully_ctrl.sv
hdl/bully_election_node.sv
dv/bully_election_node_test.sv
